@@ hw/rtl/hir_pkg.sv @@
// Package for the homography inlier ratio block.
// Payload types, controller/datapath command and status, register indexes.
// No dependencies.
package hir_pkg;

	localparam int ACC_W = 56;  // signed accumulator for one projected coordinate
	localparam int DEN_W = 56;  // divisor magnitude
	localparam int DIV_W = 64;  // dividend and quotient
	localparam int STEP_W = 7;  // divider step count, holds DIV_W

	localparam logic [2:0] REG_H11_H12 = 3'd0;
	localparam logic [2:0] REG_H13_H21 = 3'd1;
	localparam logic [2:0] REG_H22_H23 = 3'd2;
	localparam logic [2:0] REG_H31_H32 = 3'd3;
	localparam logic [2:0] REG_H33 = 3'd4;
	localparam logic [2:0] REG_LIMIT = 3'd5;

	localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
	localparam logic [31:0] SAT_NEG = 32'h8000_0000;

	typedef struct packed {
		logic signed [19:0] src_x;
		logic signed [19:0] src_y;
		logic signed [19:0] dst_x;
		logic signed [19:0] dst_y;
		logic               last_match;
	} in_item_t;

	typedef struct packed {
		logic        is_inlier;
		logic        degenerate;
		logic [16:0] inlier_count;
		logic [16:0] match_count;
		logic        ratio_valid;
		logic [16:0] set_ratio;
	} out_item_t;

	typedef enum logic [1:0] {
		DIV_X = 2'd0,
		DIV_Y = 2'd1,
		DIV_R = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     mac_start;
		logic     chk;
		logic     div_start;
		div_sel_t div_sel;
		logic     err;
		logic     sq;
		logic     cmp;
		logic     upd;
		logic     emit;
	} cmd_t;

	typedef struct packed {
		logic mac_done;
		logic w_zero;
		logic div_done;
		logic ratio_go;
	} sts_t;

endpackage

@@ hw/rtl/hir_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Dividend is left aligned; steps sets how many quotient bits are formed.
// Uses hir_pkg.
module hir_div import hir_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [STEP_W-1:0] steps,
	output logic              done,
	output logic [DIV_W-1:0]  quo
);

	logic [DIV_W-1:0]  num_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    trial;
	logic              fit;

	assign trial = {rem_q, num_q[DIV_W-1]};
	assign fit = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], 1'b0};
			rem_q <= fit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fit};
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

@@ hw/rtl/hir_datapath.sv @@
// Datapath: configuration registers, multiply-accumulate, divider, distance
// test, counters and result register. Uses hir_pkg and hir_div.
module hir_datapath import hir_pkg::*; #(
	parameter int MAX_MATCHES = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_data,
	input  in_item_t   item,
	input  cmd_t       cmd,
	output sts_t       sts,
	output out_item_t  result
);

	localparam int CW = $clog2(MAX_MATCHES + 1);
	localparam int RN = CW + 16;

	logic [63:0] r_h11_h12_q, r_h13_h21_q, r_h22_h23_q, r_h31_h32_q;
	logic [31:0] r_h33_q;
	logic [15:0] r_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_h11_h12_q <= 64'h0001_0000_0000_0000;
			r_h13_h21_q <= '0;
			r_h22_h23_q <= 64'h0001_0000_0000_0000;
			r_h31_h32_q <= '0;
			r_h33_q <= 32'h0001_0000;
			r_lim_q <= 16'd243;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_H11_H12: r_h11_h12_q <= cfg_data;
				REG_H13_H21: r_h13_h21_q <= cfg_data;
				REG_H22_H23: r_h22_h23_q <= cfg_data;
				REG_H31_H32: r_h31_h32_q <= cfg_data;
				REG_H33:     r_h33_q <= cfg_data[31:0];
				REG_LIMIT:   r_lim_q <= cfg_data[15:0];
				default:     ;
			endcase
		end
	end

	in_item_t item_q;
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= item;
	end

	// MAC: one 32x21 product per cycle, nine in all, row by row
	logic [1:0] row_q, col_q;
	logic       mac_busy_q;
	logic signed [52:0] prod_s1;
	logic [1:0] prod_row_s1;
	logic       prod_v_s1, prod_last_s1;
	logic signed [ACC_W-1:0] acc_x_q, acc_y_q, acc_w_q;
	logic signed [31:0] coef;
	logic signed [20:0] opnd;

	always_comb begin
		case ({row_q, col_q})
			4'b0000: coef = r_h11_h12_q[63:32];
			4'b0001: coef = r_h11_h12_q[31:0];
			4'b0010: coef = r_h13_h21_q[63:32];
			4'b0100: coef = r_h13_h21_q[31:0];
			4'b0101: coef = r_h22_h23_q[63:32];
			4'b0110: coef = r_h22_h23_q[31:0];
			4'b1000: coef = r_h31_h32_q[63:32];
			4'b1001: coef = r_h31_h32_q[31:0];
			default: coef = r_h33_q;
		endcase
		case (col_q)
			2'd0:    opnd = 21'(item_q.src_x);
			2'd1:    opnd = 21'(item_q.src_y);
			default: opnd = 21'sd256;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_busy_q <= 1'b0;
			prod_v_s1 <= 1'b0;
			prod_last_s1 <= 1'b0;
			row_q <= '0;
			col_q <= '0;
		end else begin
			prod_v_s1 <= mac_busy_q;
			prod_last_s1 <= mac_busy_q && row_q == 2'd2 && col_q == 2'd2;
			if (cmd.mac_start) begin
				mac_busy_q <= 1'b1;
				row_q <= '0;
				col_q <= '0;
			end else if (mac_busy_q) begin
				if (col_q == 2'd2) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
					if (row_q == 2'd2) mac_busy_q <= 1'b0;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= coef * opnd;
		prod_row_s1 <= row_q;
		if (cmd.mac_start) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_w_q <= '0;
		end else if (prod_v_s1) begin
			case (prod_row_s1)
				2'd0:    acc_x_q <= acc_x_q + ACC_W'(prod_s1);
				2'd1:    acc_y_q <= acc_y_q + ACC_W'(prod_s1);
				default: acc_w_q <= acc_w_q + ACC_W'(prod_s1);
			endcase
		end
	end

	// shared divider
	logic [DIV_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic [STEP_W-1:0] div_steps;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;
	logic [ACC_W-1:0]  mag_x, mag_y, mag_w;
	logic [CW-1:0]     inl_q, mat_q;
	div_sel_t          sel_q;
	logic              neg_x_q, neg_y_q;

	assign mag_x = acc_x_q[ACC_W-1] ? ACC_W'(-acc_x_q) : ACC_W'(acc_x_q);
	assign mag_y = acc_y_q[ACC_W-1] ? ACC_W'(-acc_y_q) : ACC_W'(acc_y_q);
	assign mag_w = acc_w_q[ACC_W-1] ? ACC_W'(-acc_w_q) : ACC_W'(acc_w_q);

	always_comb begin
		case (cmd.div_sel)
			DIV_X: begin
				div_num = {mag_x, 8'b0};
				div_den = mag_w;
				div_steps = STEP_W'(DIV_W);
			end
			DIV_Y: begin
				div_num = {mag_y, 8'b0};
				div_den = mag_w;
				div_steps = STEP_W'(DIV_W);
			end
			default: begin
				// inliers << 16, left aligned
				div_num = DIV_W'(inl_q) << (DIV_W - CW);
				div_den = DEN_W'(mat_q);
				div_steps = STEP_W'(RN);
			end
		endcase
	end

	hir_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.steps (div_steps),
		.done  (div_done),
		.quo   (div_quo)
	);

	function automatic logic [31:0] sat_q(input logic neg, input logic [DIV_W-1:0] q);
		logic [31:0] r;
		if (neg) r = (q > DIV_W'(SAT_NEG)) ? SAT_NEG : 32'(-q[31:0]);
		else r = (q > DIV_W'(SAT_POS)) ? SAT_POS : q[31:0];
		return r;
	endfunction

	logic signed [31:0] px_q, py_q;
	logic [16:0]        ratio_q;
	logic               degen_q, inl_flag_q, last_q;
	logic [32:0]        ex_abs, ey_abs;
	logic signed [32:0] ex_d, ey_d;
	logic [15:0]        ex_q, ey_q;
	logic               lt_q;
	logic [31:0]        sqx_s1, sqy_s1, lsq_s1;

	assign ex_d = 33'(px_q) - 33'(item_q.dst_x);
	assign ey_d = 33'(py_q) - 33'(item_q.dst_y);
	assign ex_abs = ex_d[32] ? 33'(-ex_d) : 33'(ex_d);
	assign ey_abs = ey_d[32] ? 33'(-ey_d) : 33'(ey_d);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			sel_q <= cmd.div_sel;
			neg_x_q <= acc_x_q[ACC_W-1] ^ acc_w_q[ACC_W-1];
			neg_y_q <= acc_y_q[ACC_W-1] ^ acc_w_q[ACC_W-1];
		end
		if (div_done) begin
			case (sel_q)
				DIV_X:   px_q <= sat_q(neg_x_q, div_quo);
				DIV_Y:   py_q <= sat_q(neg_y_q, div_quo);
				default: ratio_q <= div_quo[16:0];
			endcase
		end
		if (cmd.err) begin
			ex_q <= ex_abs[15:0];
			ey_q <= ey_abs[15:0];
			lt_q <= ex_abs < 33'(r_lim_q) && ey_abs < 33'(r_lim_q);
		end
		if (cmd.sq) begin
			sqx_s1 <= ex_q * ex_q;
			sqy_s1 <= ey_q * ey_q;
			lsq_s1 <= r_lim_q * r_lim_q;
		end
		if (cmd.chk) begin
			degen_q <= acc_w_q == '0;
			inl_flag_q <= 1'b0;
			last_q <= item_q.last_match;
		end
		if (cmd.cmp) inl_flag_q <= lt_q && (33'(sqx_s1) + 33'(sqy_s1)) < 33'(lsq_s1);
		if (cmd.upd) ratio_q <= '0;
		if (cmd.emit) begin
			result.is_inlier <= inl_flag_q;
			result.degenerate <= degen_q;
			result.inlier_count <= 17'(inl_q);
			result.match_count <= 17'(mat_q);
			result.ratio_valid <= last_q;
			result.set_ratio <= ratio_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inl_q <= '0;
			mat_q <= '0;
		end else if (cmd.upd) begin
			if (mat_q < CW'(MAX_MATCHES)) begin
				mat_q <= mat_q + 1'b1;
				if (inl_flag_q) inl_q <= inl_q + 1'b1;
			end
		end else if (cmd.emit && last_q) begin
			inl_q <= '0;
			mat_q <= '0;
		end
	end

	assign sts.mac_done = prod_v_s1 && prod_last_s1;
	assign sts.w_zero = acc_w_q == '0;
	assign sts.div_done = div_done;
	assign sts.ratio_go = last_q && mat_q != '0;

endmodule

@@ hw/rtl/hir_ctrl.sv @@
// Controller state machine: sequences one item through the datapath and
// owns the input ready and result valid. Uses hir_pkg.
module hir_ctrl import hir_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	output logic result_valid,
	input  logic result_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_MAC   = 12'b0000_0000_0010,
		S_CHK   = 12'b0000_0000_0100,
		S_DIVX  = 12'b0000_0000_1000,
		S_DIVY  = 12'b0000_0001_0000,
		S_ERR   = 12'b0000_0010_0000,
		S_SQ    = 12'b0000_0100_0000,
		S_CMP   = 12'b0000_1000_0000,
		S_UPD   = 12'b0001_0000_0000,
		S_RAT   = 12'b0010_0000_0000,
		S_RWAIT = 12'b0100_0000_0000,
		S_DONE  = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   valid_q;
	logic   out_free;

	assign item_ready = state_q == S_IDLE;
	assign out_free = !valid_q || result_ready;
	assign result_valid = valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.div_sel = DIV_X;
		case (state_q)
			S_IDLE: if (item_valid) begin
				cmd.load = 1'b1;
				cmd.mac_start = 1'b1;
				state_d = S_MAC;
			end
			S_MAC: if (sts.mac_done) state_d = S_CHK;
			S_CHK: begin
				cmd.chk = 1'b1;
				if (sts.w_zero) begin
					state_d = S_UPD;
				end else begin
					cmd.div_start = 1'b1;
					state_d = S_DIVX;
				end
			end
			S_DIVX: if (sts.div_done) begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DIV_Y;
				state_d = S_DIVY;
			end
			S_DIVY: if (sts.div_done) state_d = S_ERR;
			S_ERR: begin
				cmd.err = 1'b1;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.sq = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_RAT;
			end
			S_RAT: begin
				cmd.div_sel = DIV_R;
				if (sts.ratio_go) begin
					cmd.div_start = 1'b1;
					state_d = S_RWAIT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RWAIT: if (sts.div_done) state_d = S_DONE;
			S_DONE: if (out_free) begin
				cmd.emit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) valid_q <= 1'b1;
			else if (result_ready) valid_q <= 1'b0;
		end
	end

endmodule

@@ hw/rtl/homography_inlier_ratio_top.sv @@
// Homography reprojection inlier counter, top level.
// Joins hir_ctrl and hir_datapath; uses hir_pkg.
//
// Channels: item (valid/ready) carries one matched point pair; result
// (valid/ready) returns one item per pair; cfg (valid/ready, index, data)
// writes the six registers and is always ready; the user must write them
// only while the block is idle; the block itself does not enforce it.
// One item is worked on at a time. The next item is taken the cycle after
// the result is written. The divider is shared, one quotient bit per
// cycle: 64 steps each for x/w and y/w, CW + 16 steps for the ratio on
// the last item of a set (CW = bits of the match counter); nine products
// go through one multiplier.
// The result sits in an output register: a new item is accepted while the
// previous result waits, and a stalled receiver holds the block only when
// the next result is ready to be written.
// Reset restores the identity homography, a limit of 0.95 pixel and clears
// both counters and any pending result.
module homography_inlier_ratio_top import hir_pkg::*; #(
	parameter int MAX_MATCHES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  in_item_t    item,
	output logic        result_valid,
	input  logic        result_ready,
	output out_item_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	hir_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	hir_datapath #(.MAX_MATCHES(MAX_MATCHES)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (item),
		.cmd      (cmd),
		.sts      (sts),
		.result   (result)
	);

	a_inl_not_degen: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.is_inlier && result.degenerate))
		else $error("degenerate pair reported as inlier");

	a_ratio_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.ratio_valid |-> result.set_ratio == '0)
		else $error("ratio nonzero on an item that is not last");

	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.inlier_count <= result.match_count)
		else $error("more inliers than matches");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("second item taken while one is in flight");

endmodule

@@ tb/hir_checker.sv @@
// Checker for the homography inlier ratio block: watches the cfg, item and result channels.
// It predicts each result from its own copy of the registers and counters and compares them.
// Depends on hir_pkg.
`timescale 1ns / 100ps

module hir_checker import hir_pkg::*; #(
	parameter int MAX_MATCHES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_ready,
	input  in_item_t    item,
	input  logic        result_valid,
	input  logic        result_ready,
	input  out_item_t   result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	logic [63:0] hreg [6];
	longint      inliers_seen;
	longint      matches_seen;
	out_item_t   awaited_results[$];

	function automatic longint upper_q(logic [63:0] r);
		return longint'(signed'(r[63:32]));
	endfunction

	function automatic longint lower_q(logic [63:0] r);
		return longint'(signed'(r[31:0]));
	endfunction

	// x/w or y/w in Q.8, truncated toward zero, saturated to 32 bits
	function automatic longint project_coord(longint acc, longint w);
		longint q;
		q = (acc * 256) / w;
		if (q > Q_MAX) q = Q_MAX;
		if (q < Q_MIN) q = Q_MIN;
		return q;
	endfunction

	// Evaluates one pair, advances the set counters and clears them after the last pair of a set.
	function automatic out_item_t score_pair(in_item_t p);
		out_item_t r;
		longint sx, sy, ax, ay, aw, px, py, ex, ey, lim;
		logic inl;
		sx = longint'(p.src_x);
		sy = longint'(p.src_y);
		ax = upper_q(hreg[REG_H11_H12]) * sx + lower_q(hreg[REG_H11_H12]) * sy
			+ upper_q(hreg[REG_H13_H21]) * 256;
		ay = lower_q(hreg[REG_H13_H21]) * sx + upper_q(hreg[REG_H22_H23]) * sy
			+ lower_q(hreg[REG_H22_H23]) * 256;
		aw = upper_q(hreg[REG_H31_H32]) * sx + lower_q(hreg[REG_H31_H32]) * sy
			+ lower_q(hreg[REG_H33]) * 256;
		lim = longint'(hreg[REG_LIMIT][15:0]);
		inl = 1'b0;
		if (aw != 0) begin
			px = project_coord(ax, aw) - longint'(p.dst_x);
			py = project_coord(ay, aw) - longint'(p.dst_y);
			ex = px < 0 ? -px : px;
			ey = py < 0 ? -py : py;
			if (ex < lim && ey < lim)
				inl = (ex * ex + ey * ey) < lim * lim;
		end
		if (matches_seen < MAX_MATCHES) begin
			matches_seen++;
			if (inl) inliers_seen++;
		end
		r.is_inlier    = inl;
		r.degenerate   = (aw == 0);
		r.inlier_count = inliers_seen[16:0];
		r.match_count  = matches_seen[16:0];
		r.ratio_valid  = p.last_match;
		r.set_ratio    = '0;
		if (p.last_match && matches_seen != 0)
			r.set_ratio = 17'((inliers_seen << 16) / matches_seen);
		if (p.last_match) begin
			inliers_seen = 0;
			matches_seen = 0;
		end
		return r;
	endfunction

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			hreg[REG_H11_H12] = 64'h0001_0000_0000_0000;
			hreg[REG_H13_H21] = '0;
			hreg[REG_H22_H23] = 64'h0001_0000_0000_0000;
			hreg[REG_H31_H32] = '0;
			hreg[REG_H33]     = 64'd65536;
			hreg[REG_LIMIT]   = 64'd243;
			inliers_seen = 0;
			matches_seen = 0;
			awaited_results.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_H33:   hreg[REG_H33] = {32'd0, cfg_data[31:0]};
					REG_LIMIT: hreg[REG_LIMIT] = {48'd0, cfg_data[15:0]};
					REG_H11_H12, REG_H13_H21, REG_H22_H23, REG_H31_H32:
						hreg[cfg_index] = cfg_data;
					default: ;
				endcase
			end
			if (item_valid && item_ready)
				awaited_results = {awaited_results, score_pair(item)};
			if (result_valid && result_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result with no item outstanding");
					fail_count++;
				end else begin
					e = awaited_results.pop_front();
					check_field("is_inlier", e.is_inlier, result.is_inlier);
					check_field("degenerate", e.degenerate, result.degenerate);
					check_field("inlier_count", e.inlier_count, result.inlier_count);
					check_field("match_count", e.match_count, result.match_count);
					check_field("ratio_valid", e.ratio_valid, result.ratio_valid);
					check_field("set_ratio", e.set_ratio, result.set_ratio);
				end
			end
		end
		pending = awaited_results.size();
	end

endmodule

@@ tb/tb.sv @@
// Testbench top for homography_inlier_ratio_top: clock, reset, stimulus and verdict.
// Uses hir_pkg and the hir_checker module for prediction and comparison.
`timescale 1ns / 100ps

module tb import hir_pkg::*;;

	localparam logic [2:0] REG_UNUSED = 3'd6;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int RANDOM_PHASES = 9;
	localparam int PAIRS_PER_PHASE = 205;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	in_item_t    item;
	logic        result_valid;
	logic        result_ready;
	out_item_t   result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	int          fail_count;
	int          pending;
	int          tx_idle;
	int          rx_idle;
	int          cycles;

	homography_inlier_ratio_top i_dut (.*);

	hir_checker i_checker (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= rx_idle);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic in_item_t pair(int sx, int sy, int dx, int dy, bit last);
		in_item_t p;
		p.src_x = 20'(sx);
		p.src_y = 20'(sy);
		p.dst_x = 20'(dx);
		p.dst_y = 20'(dy);
		p.last_match = last;
		return p;
	endfunction

	// Called at a rising edge; returns at the edge where the item is taken.
	task automatic send_pair(in_item_t p);
		while ($urandom_range(99) < tx_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= p;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_homography(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
			logic [63:0] r3, logic [31:0] h33, logic [15:0] lim);
		write_reg(REG_H11_H12, r0);
		write_reg(REG_H13_H21, r1);
		write_reg(REG_H22_H23, r2);
		write_reg(REG_H31_H32, r3);
		write_reg(REG_H33, {32'd0, h33});
		write_reg(REG_LIMIT, {48'd0, lim});
		@(posedge clk);
	endtask

	function automatic logic [31:0] near(int base, int spread);
		return 32'(base + $urandom_range(2 * spread) - spread);
	endfunction

	task automatic random_phase(int n);
		in_item_t p;
		int sel, sx, sy;
		sel = $urandom_range(5);
		if (sel == 0)
			load_homography({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, $urandom, 16'($urandom));
		else if (sel == 1)
			// w is zero wherever src_x is zero
			load_homography({near(65536, 64), 32'd0}, 64'd0, {near(65536, 64), 32'd0},
				{32'd65536, 32'd0}, 32'd0, 16'($urandom_range(2000)));
		else
			load_homography({near(65536, 256), near(0, 256)}, {near(0, 65536), near(0, 256)},
				{near(65536, 256), near(0, 65536)}, {near(0, 2), near(0, 2)},
				near(65536, 256), 16'($urandom_range(1000)));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(4) == 0) begin
				p = in_item_t'(81'({$urandom, $urandom, $urandom}));
			end else begin
				sx = $urandom_range(8000) - 4000;
				sy = $urandom_range(8000) - 4000;
				if ($urandom_range(9) == 0) sx = 0;
				p = pair(sx, sy, sx + $urandom_range(600) - 300,
					sy + $urandom_range(600) - 300, 1'b0);
			end
			p.last_match = ($urandom_range(19) == 0) || (i == n - 1);
			send_pair(p);
			if (i == n / 2 && $urandom_range(1) == 0) drain();
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_H11_H12;
		cfg_data = '0;
		tx_idle = 0;
		rx_idle = 0;
		cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: identity, limit just under one pixel
		send_pair(pair(0, 0, 0, 0, 0));
		send_pair(pair(256, 256, 498, 256, 0));
		send_pair(pair(256, 256, 499, 256, 0));
		send_pair(pair(-524288, 524287, -524288, 524287, 0));
		send_pair(pair(524287, -524288, -524288, 524287, 0));
		send_pair(pair(100, 100, 271, 271, 0));
		send_pair(pair(100, 100, 272, 272, 1));
		send_pair(pair(5, 5, 5, 5, 1));
		drain();
		// zero limit: nothing is an inlier
		write_reg(REG_LIMIT, 64'd0);
		@(posedge clk);
		send_pair(pair(0, 0, 0, 0, 1));
		drain();
		// w identically zero
		load_homography(64'h0000_0001_0000_0000, 64'd0, 64'h0000_0001_0000_0000, 64'd0,
			32'd0, 16'hffff);
		send_pair(pair(10, 10, 10, 10, 0));
		send_pair(pair(0, 0, 0, 0, 1));
		drain();
		load_homography(64'h0000_0001_0000_0000, 64'd0, 64'h0000_0001_0000_0000,
			64'h0001_0000_0000_0000, 32'd0, 16'hffff);
		send_pair(pair(0, 77, 0, 0, 0));
		send_pair(pair(256, 0, 256, 0, 1));
		drain();
		// extreme coefficients with a tiny w, drives saturation
		write_reg(REG_UNUSED, 64'hffff_ffff_ffff_ffff);
		load_homography(64'h7fff_ffff_8000_0000, 64'h8000_0000_7fff_ffff,
			64'h7fff_ffff_7fff_ffff, 64'd0, 32'd1, 16'hffff);
		send_pair(pair(524287, 524287, 524287, -524288, 0));
		send_pair(pair(-524288, -524288, -524288, 524287, 0));
		send_pair(pair(1, -1, 0, 0, 1));
		drain();
		load_homography(64'h0000_0001_0000_0000, 64'd0, 64'h0000_0001_0000_0000, 64'd0,
			32'h8000_0000, 16'd243);
		send_pair(pair(300, -300, 0, 0, 1));
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < RANDOM_PHASES / 3) begin
				tx_idle = 6;
				rx_idle = 49;
			end else if (ph < 2 * RANDOM_PHASES / 3) begin
				tx_idle = 49;
				rx_idle = 6;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			random_phase(PAIRS_PER_PHASE);
		end

		repeat (250) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/hir_pkg.sv
hw/rtl/hir_div.sv
hw/rtl/hir_datapath.sv
hw/rtl/hir_ctrl.sv
hw/rtl/homography_inlier_ratio_top.sv
tb/hir_checker.sv
tb/tb.sv
